// ----- hw/rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;

   // Command codes carried by the cmd field of a request beat.
   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2
   } cmd_type;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Broadcast from the controller to every cell in the chain.
   typedef struct packed {
      logic      do_insert;
      logic      do_remove;
      value_type value;
   } ctrl_type;

   // Comparison flags handed from one cell to the next.
   typedef struct packed {
      logic gt;
      logic ge;
   } flag_type;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// One storage cell of the sorted chain: holds an entry, compares and shifts.
module spq_cell (
   input  logic                clock,
   input  spq_pkg::ctrl_type   ctrl,
   input  spq_pkg::flag_type   prev_flags,
   input  logic                occupied,
   input  spq_pkg::value_type  left_value,
   input  spq_pkg::value_type  right_value,
   output spq_pkg::value_type  value,
   output spq_pkg::flag_type   flags,
   output logic                ins_hit,
   output logic                fnd_hit
);

   spq_pkg::value_type value_ff;
   spq_pkg::value_type value_in;

   // Compare the stored entry with the broadcast value.
   always_comb begin
      flags.gt = occupied && (value_ff > ctrl.value);
      flags.ge = occupied && (value_ff >= ctrl.value);
   end

   // This cell is the insert slot when it is the first one not at least the value,
   // and the match when it is the first one not greater and holds the value.
   assign ins_hit = prev_flags.ge & ~flags.ge;
   assign fnd_hit = prev_flags.gt & occupied & (value_ff == ctrl.value);
   assign value   = value_ff;

   // Insert shifts entries towards the tail; remove pulls them towards the head.
   always_comb begin
      value_in = value_ff;
      if (ctrl.do_insert) begin
         if (ins_hit) begin
            value_in = ctrl.value;
         end else if (!prev_flags.ge) begin
            value_in = left_value;
         end
      end else if (ctrl.do_remove) begin
         if (!flags.gt) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: request stage, cell chain and response register.
//
// Keeps up to CAPACITY signed 32-bit values in descending order in a chain of cells, the
// greatest at position 0. Each request beat inserts, removes one occurrence of, or finds a
// value; each yields one response beat with the outcome, position, count, head value and
// empty flag as they stand after the command. A request is registered on acceptance and
// executed once the response register is free or draining, when every cell compares its
// entry with the value at once and shifts by one place; the response lands in an output
// register. One request can be accepted per cycle while responses are taken. A request
// is taken while a response still waits. Inserts into a full queue are refused.
module sorted_priority_queue #(
   parameter int CAPACITY = 64,
   localparam int POS_W   = $clog2(CAPACITY + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [spq_pkg::CMD_W-1:0]     req_cmd,
   input  logic signed [spq_pkg::VALUE_W-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_ok,
   output logic [POS_W-1:0]              rsp_position,
   output logic [POS_W-1:0]              rsp_count,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_head_value,
   output logic                          rsp_empty_res
);

   // Request stage.
   logic                        x_valid_ff, x_valid_in;
   logic [spq_pkg::CMD_W-1:0]   x_cmd_ff;
   spq_pkg::value_type          x_value_ff;
   logic                        x_go;

   // Queue state and response register.
   logic [POS_W-1:0]            count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        ok_ff;
   logic [POS_W-1:0]            pos_ff;
   logic [POS_W-1:0]            cnt_ff;
   spq_pkg::value_type          head_ff;

   // Chain signals.
   spq_pkg::ctrl_type           ctrl;
   spq_pkg::flag_type           chain_flags [CAPACITY+1];
   spq_pkg::value_type          cell_value  [CAPACITY];
   logic [CAPACITY-1:0]         occupied;
   logic [CAPACITY-1:0]         ins_hit;
   logic [CAPACITY-1:0]         fnd_hit;

   logic                        is_insert, is_remove, is_find;
   logic                        full, found;
   logic [POS_W-1:0]            ins_pos, fnd_pos;
   logic                        res_ok;
   logic [POS_W-1:0]            res_pos;
   spq_pkg::value_type          head_cand;

   // The request stage executes once the response register is free or draining.
   assign x_go       = x_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready  = ~x_valid_ff | x_go;
   assign x_valid_in = (req_valid & req_ready) | (x_valid_ff & ~x_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_cmd_ff   <= req_cmd;
         x_value_ff <= req_value;
      end
   end

   // Decode the held command.
   always_comb begin
      is_insert = 1'b0;
      is_remove = 1'b0;
      is_find   = 1'b0;
      case (x_cmd_ff)
         spq_pkg::CMD_INSERT: is_insert = 1'b1;
         spq_pkg::CMD_REMOVE: is_remove = 1'b1;
         spq_pkg::CMD_FIND:   is_find   = 1'b1;
         default: ;
      endcase
   end

   assign full  = (count_ff == POS_W'(CAPACITY));
   assign found = |fnd_hit;

   assign ctrl.do_insert = x_go & is_insert & ~full;
   assign ctrl.do_remove = x_go & is_remove & found;
   assign ctrl.value     = x_value_ff;

   // The head of the chain behaves as if preceded by an entry greater than anything.
   assign chain_flags[0] = '{gt: 1'b1, ge: 1'b1};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (POS_W'(i) < count_ff);

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .prev_flags  (chain_flags[i]),
         .occupied    (occupied[i]),
         .left_value  ((i == 0) ? x_value_ff : cell_value[(i == 0) ? 0 : i-1]),
         .right_value (cell_value[(i == CAPACITY-1) ? i : i+1]),
         .value       (cell_value[i]),
         .flags       (chain_flags[i+1]),
         .ins_hit     (ins_hit[i]),
         .fnd_hit     (fnd_hit[i])
      );
   end

   // Encode the single marked cell into a position.
   always_comb begin
      ins_pos = '0;
      fnd_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_hit[i]) begin
            ins_pos = ins_pos | POS_W'(i);
         end
         if (fnd_hit[i]) begin
            fnd_pos = fnd_pos | POS_W'(i);
         end
      end
   end

   // Outcome and the state after the command.
   always_comb begin
      res_ok    = 1'b0;
      res_pos   = '0;
      count_in  = count_ff;
      head_cand = cell_value[0];
      if (is_insert && !full) begin
         res_ok   = 1'b1;
         res_pos  = ins_pos;
         count_in = count_ff + POS_W'(1);
         if (ins_hit[0]) begin
            head_cand = x_value_ff;
         end
      end else if ((is_remove || is_find) && found) begin
         res_ok  = 1'b1;
         res_pos = fnd_pos;
         if (is_remove) begin
            count_in = count_ff - POS_W'(1);
            if (fnd_hit[0]) begin
               head_cand = cell_value[1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (x_go) begin
         count_ff <= count_in;
      end
   end

   // Response register.
   assign rsp_valid_in = x_go | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_go) begin
         ok_ff   <= res_ok;
         pos_ff  <= res_pos;
         cnt_ff  <= count_in;
         head_ff <= (count_in == '0) ? '0 : head_cand;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_position   = pos_ff;
   assign rsp_count      = cnt_ff;
   assign rsp_head_value = head_ff;
   assign rsp_empty_res  = (cnt_ff == '0);

endmodule
